[src/t3pe_pkg.sv]
// package: shared constants and types for the 3d turtle path engine
package t3pe_pkg;

    localparam int HistoryDepthDefault = 64;
    localparam int MarkDepthDefault    = 32;

    // operation codes
    localparam logic [2:0] OP_ROT_X   = 3'd0;
    localparam logic [2:0] OP_ROT_Y   = 3'd1;
    localparam logic [2:0] OP_ROT_Z   = 3'd2;
    localparam logic [2:0] OP_MOVE    = 3'd3;
    localparam logic [2:0] OP_SAVE    = 3'd4;
    localparam logic [2:0] OP_RESTORE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_VERTEX  = 2'd0;
    localparam logic [1:0] KIND_HEADING = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_NO_SAVE  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_X   = 3'd0;
    localparam logic [2:0] REG_START_Y   = 3'd1;
    localparam logic [2:0] REG_START_Z   = 3'd2;
    localparam logic [2:0] REG_START_DX  = 3'd3;
    localparam logic [2:0] REG_START_DY  = 3'd4;
    localparam logic [2:0] REG_START_DZ  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_WRITE,
        S_MREAD,
        S_MWAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_OUT
    } t_state;

    // floor shift by 14 of a 34 bit sum, saturated to 16 bits
    function automatic logic signed [15:0] sat_rot(input logic signed [33:0] v);
        logic signed [19:0] sh;
        sh = 20'(v >>> 14);
        if (sh > 20'sd32767) return 16'sh7fff;
        else if (sh < -20'sd32768) return 16'sh8000;
        else return sh[15:0];
    endfunction

    // position plus floor(product / 2^14), saturated to 32 bits
    function automatic logic signed [31:0] sat_move(input logic signed [31:0] p,
                                                    input logic signed [47:0] prod);
        logic signed [34:0] sum;
        sum = 35'(p) + 35'(prod >>> 14);
        if (sum > 35'sd2147483647) return 32'sh7fffffff;
        else if (sum < -35'sd2147483648) return 32'sh80000000;
        else return sum[31:0];
    endfunction

endpackage

[src/t3pe_ram.sv]
// generic single port write, single port read ram with registered read
module t3pe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/turtle_3d_path_engine.sv]
// top level of the 3d turtle path engine
// Items are taken one at a time. A rotate or move item puts its result on the output
// through memory read, multiply, one spare stage, then sum, saturate and write back as
// the result is loaded; the next item is taken only once that result is loaded. A save,
// an overflow, a restore without save or an unused code answers in the cycle after accept.
// A restore reads its mark and then walks back; when it uncovers no position it answers
// with a status, otherwise it gives one vertex per uncovered position, each further vertex
// after a wait and an output state. Output stalls hold back rotate, move and restore results.
// Stack bottoms (start position and heading) are read straight from the start
// registers; the rest of each history stack and the marks live in synchronous rams with one
// write and one read port. Any configuration write restarts the turtle from the start
// registers at once.
module turtle_3d_path_engine
    import t3pe_pkg::*;
#(
    parameter int HISTORY_DEPTH = HistoryDepthDefault,
    parameter int MARK_DEPTH    = MarkDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [15:0] i_cos_value,
    input  logic signed [15:0] i_sin_value,
    input  logic signed [31:0] i_distance,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [31:0] o_comp_x,
    output logic signed [31:0] o_comp_y,
    output logic signed [31:0] o_comp_z,
    output logic [1:0]         o_status,
    output logic               o_last
);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int DW = $clog2(HISTORY_DEPTH + 1);
    localparam int MW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int MCW = $clog2(MARK_DEPTH + 1);

    // start registers
    logic signed [31:0] r_sx, r_sy, r_sz;
    logic signed [15:0] r_sdx, r_sdy, r_sdz;

    logic [DW-1:0]  r_pdepth, n_pdepth, r_hdepth, n_hdepth, r_pto, n_pto;
    logic [MCW-1:0] r_mdepth, n_mdepth;
    t_state r_state, n_state;

    logic [2:0] r_op;
    logic signed [15:0] r_c, r_s;
    logic signed [31:0] r_dist;

    // rams
    logic            pos_we, head_we, mark_we;
    logic [HW-1:0]   pos_waddr, pos_raddr, head_waddr, head_raddr;
    logic [95:0]     pos_wdata, pos_rdata;
    logic [47:0]     head_wdata, head_rdata;
    logic [MW-1:0]   mark_addr_w, mark_addr_r;
    logic [2*DW-1:0] mark_wdata, mark_rdata;

    t3pe_ram #(.WIDTH(96), .DEPTH(HISTORY_DEPTH)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata));
    t3pe_ram #(.WIDTH(48), .DEPTH(HISTORY_DEPTH)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata));
    t3pe_ram #(.WIDTH(2*DW), .DEPTH(MARK_DEPTH)) u_mark (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_addr_w), .i_wdata(mark_wdata),
        .i_raddr(mark_addr_r), .o_rdata(mark_rdata));

    // top-of-stack values: bottom entry comes from the start registers
    logic r_pbot, r_hbot;
    logic signed [31:0] top_px, top_py, top_pz;
    logic signed [15:0] top_hx, top_hy, top_hz;
    always_comb begin
        if (r_pbot) begin
            top_px = r_sx; top_py = r_sy; top_pz = r_sz;
        end else begin
            top_px = pos_rdata[95:64]; top_py = pos_rdata[63:32];
            top_pz = pos_rdata[31:0];
        end
        if (r_hbot) begin
            top_hx = r_sdx; top_hy = r_sdy; top_hz = r_sdz;
        end else begin
            top_hx = head_rdata[47:32]; top_hy = head_rdata[31:16];
            top_hz = head_rdata[15:0];
        end
    end

    // latched operands and products
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_hx, r_hy, r_hz;
    logic signed [31:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [47:0] r_q0, r_q1, r_q2;

    // rotation operand selection: result a = p0 (-/+) p1, b = p2 (+/-) p3
    logic signed [15:0] ra, rb;
    always_comb begin
        case (r_op)
            OP_ROT_X: begin ra = r_hy; rb = r_hz; end
            OP_ROT_Y: begin ra = r_hx; rb = r_hz; end
            default:  begin ra = r_hx; rb = r_hy; end
        endcase
    end

    // rotated heading
    logic signed [15:0] nhx, nhy, nhz;
    always_comb begin
        nhx = r_hx; nhy = r_hy; nhz = r_hz;
        case (r_op)
            OP_ROT_X: begin
                nhy = sat_rot(34'(r_m0) - 34'(r_m1));
                nhz = sat_rot(34'(r_m2) + 34'(r_m3));
            end
            OP_ROT_Y: begin
                // x = hx*c + hz*s ; z = hz*c - hx*s
                nhx = sat_rot(34'(r_m0) + 34'(r_m1));
                nhz = sat_rot(34'(r_m2) - 34'(r_m3));
            end
            default: begin
                nhx = sat_rot(34'(r_m0) - 34'(r_m1));
                nhy = sat_rot(34'(r_m2) + 34'(r_m3));
            end
        endcase
    end

    // output register
    logic       r_ovalid;
    logic [1:0] r_kind, r_status;
    logic       r_last;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic signed [31:0] n_ox, n_oy, n_oz;
    logic [1:0] n_kind, n_status;
    logic       n_last, load_out;

    logic accept, out_free;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    logic [MW-1:0] mtop;
    assign mtop = MW'(r_mdepth - MCW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) begin
                if (i_operation <= OP_ROT_Z)
                    n_state = (r_hdepth >= DW'(HISTORY_DEPTH)) ? S_IDLE : S_READ;
                else if (i_operation == OP_MOVE)
                    n_state = (r_pdepth >= DW'(HISTORY_DEPTH)) ? S_IDLE : S_READ;
                else if (i_operation == OP_RESTORE && r_mdepth != '0)
                    n_state = S_MREAD;
                else
                    n_state = S_IDLE;
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_WRITE;
            S_WRITE: if (out_free) n_state = S_IDLE;
            S_MREAD: n_state = S_MWAIT;
            S_MWAIT: n_state = S_WALK_RD;
            S_WALK_RD: begin
                if (r_pto == '0 || r_pdepth <= r_pto) n_state = S_OUT;
                else n_state = S_WALK_WAIT;
            end
            S_WALK_WAIT: n_state = S_OUT;
            S_OUT: if (out_free) n_state = (r_pto != '0 && r_pdepth > r_pto) ?
                                           S_WALK_WAIT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory addresses, depth updates and result formation
    logic r_any;
    always_comb begin
        pos_we = 1'b0; head_we = 1'b0; mark_we = 1'b0;
        pos_waddr = HW'(r_pdepth); head_waddr = HW'(r_hdepth);
        pos_wdata = {n_ox, n_oy, n_oz};
        head_wdata = {nhx, nhy, nhz};
        pos_raddr = HW'(r_pdepth - DW'(1));
        head_raddr = HW'(r_hdepth - DW'(1));
        mark_addr_w = MW'(r_mdepth);
        mark_addr_r = mtop;
        mark_wdata = {r_pdepth, r_hdepth};
        n_pdepth = r_pdepth; n_hdepth = r_hdepth; n_mdepth = r_mdepth;
        n_pto = r_pto;
        load_out = 1'b0;
        n_kind = KIND_STATUS; n_status = ST_OK; n_last = 1'b1;
        n_ox = '0; n_oy = '0; n_oz = '0;
        case (r_state)
            S_IDLE: if (accept) begin
                load_out = 1'b1;
                if (i_operation <= OP_ROT_Z) begin
                    load_out = r_hdepth >= DW'(HISTORY_DEPTH);
                    n_status = ST_OVERFLOW;
                end else if (i_operation == OP_MOVE) begin
                    load_out = r_pdepth >= DW'(HISTORY_DEPTH);
                    n_status = ST_OVERFLOW;
                end else if (i_operation == OP_SAVE) begin
                    if (r_mdepth >= MCW'(MARK_DEPTH)) n_status = ST_OVERFLOW;
                    else begin
                        mark_we = 1'b1;
                        n_mdepth = r_mdepth + MCW'(1);
                    end
                end else if (i_operation == OP_RESTORE) begin
                    if (r_mdepth == '0) n_status = ST_NO_SAVE;
                    else load_out = 1'b0;
                end
            end
            S_MWAIT: begin
                n_mdepth = r_mdepth - MCW'(1);
                n_pto = mark_rdata[2*DW-1:DW];
                if (mark_rdata[DW-1:0] != '0 && mark_rdata[DW-1:0] < r_hdepth)
                    n_hdepth = mark_rdata[DW-1:0];
            end
            S_WALK_RD: begin
                if (r_pto != '0 && r_pdepth > r_pto) begin
                    n_pdepth = r_pdepth - DW'(1);
                    pos_raddr = HW'(r_pdepth - DW'(2));
                end
            end
            S_OUT: if (out_free) begin
                load_out = 1'b1;
                if (r_any) begin
                    n_kind = KIND_VERTEX;
                    n_ox = top_px; n_oy = top_py; n_oz = top_pz;
                end
                n_last = !(r_pto != '0 && r_pdepth > r_pto);
                if (!n_last) begin
                    n_pdepth = r_pdepth - DW'(1);
                    pos_raddr = HW'(r_pdepth - DW'(2));
                end
            end
            S_WRITE: begin
                if (r_op == OP_MOVE) begin
                    n_ox = sat_move(r_px, r_q0);
                    n_oy = sat_move(r_py, r_q1);
                    n_oz = sat_move(r_pz, r_q2);
                    n_kind = KIND_VERTEX;
                end else begin
                    n_ox = 32'(nhx); n_oy = 32'(nhy); n_oz = 32'(nhz);
                    n_kind = KIND_HEADING;
                end
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_op == OP_MOVE) begin
                        pos_we = 1'b1; n_pdepth = r_pdepth + DW'(1);
                    end else begin
                        head_we = 1'b1; n_hdepth = r_hdepth + DW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state  <= S_IDLE;
            r_pdepth <= DW'(1);
            r_hdepth <= DW'(1);
            r_mdepth <= '0;
            r_ovalid <= 1'b0;
            r_pto    <= '0;
        end else begin
            r_state  <= n_state;
            r_pdepth <= n_pdepth;
            r_hdepth <= n_hdepth;
            r_mdepth <= n_mdepth;
            r_pto    <= n_pto;
            if (load_out) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // start registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_sdx <= '0; r_sdy <= 16'sd16384; r_sdz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_X:  r_sx  <= i_cfg_data;
                REG_START_Y:  r_sy  <= i_cfg_data;
                REG_START_Z:  r_sz  <= i_cfg_data;
                REG_START_DX: r_sdx <= i_cfg_data[15:0];
                REG_START_DY: r_sdy <= i_cfg_data[15:0];
                REG_START_DZ: r_sdz <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // datapath registers: bottom flags track the registered read addresses
    always_ff @(posedge i_clk) begin
        r_pbot <= (pos_raddr == '0);
        r_hbot <= (head_raddr == '0);
        if (accept) begin
            r_op <= i_operation; r_c <= i_cos_value; r_s <= i_sin_value;
            r_dist <= i_distance;
        end
        if (r_state == S_MWAIT) r_any <= 1'b0;
        else if (r_state == S_WALK_RD) r_any <= (r_pto != '0 && r_pdepth > r_pto);
        if (r_state == S_READ) begin
            r_px <= top_px; r_py <= top_py; r_pz <= top_pz;
            r_hx <= top_hx; r_hy <= top_hy; r_hz <= top_hz;
        end
        if (r_state == S_MUL) begin
            r_m0 <= ra * r_c;
            r_m1 <= rb * r_s;
            r_m2 <= (r_op == OP_ROT_Y) ? rb * r_c : ra * r_s;
            r_m3 <= (r_op == OP_ROT_Y) ? ra * r_s : rb * r_c;
            r_q0 <= r_dist * r_hx;
            r_q1 <= r_dist * r_hy;
            r_q2 <= r_dist * r_hz;
        end
        if (load_out) begin
            r_kind <= n_kind; r_status <= n_status; r_last <= n_last;
            r_ox <= n_ox; r_oy <= n_oy; r_oz <= n_oz;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_kind   = r_kind;
    assign o_status = r_status;
    assign o_last   = r_last;
    assign o_comp_x = r_ox;
    assign o_comp_y = r_oy;
    assign o_comp_z = r_oz;
endmodule

[sim/turtle_3d_path_engine_test.sv]
// testbench for the 3d turtle path engine: directed, overflow and random tests
module turtle_3d_path_engine_test;
    import t3pe_pkg::*;

    localparam int Depth     = HistoryDepthDefault;
    localparam int MarkSlots = MarkDepthDefault;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         status;
        logic               last;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_operation = '0;
    logic signed [15:0] i_cos_value = '0;
    logic signed [15:0] i_sin_value = '0;
    logic signed [31:0] i_distance = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_kind;
    logic signed [31:0] o_comp_x;
    logic signed [31:0] o_comp_y;
    logic signed [31:0] o_comp_z;
    logic [1:0]         o_status;
    logic               o_last;

    // turtle state as predicted
    logic signed [31:0] start_pos [3];
    logic signed [15:0] start_dir [3];
    logic signed [31:0] pos_hist [Depth][3];
    logic signed [15:0] dir_hist [Depth][3];
    int                 pos_depth;
    int                 dir_depth;
    int                 mark_pos [MarkSlots];
    int                 mark_dir [MarkSlots];
    int                 mark_count;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      burst_left = 0;
    bit      hold_request = 1'b0;
    int      hold_cycles = 0;
    int      mode_left = 0;
    bit      steady = 1'b0;

    turtle_3d_path_engine i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // floor shift by 14, saturated to 16 bits
    function automatic logic signed [15:0] turn_component(input longint a, input longint c,
                                                          input longint b, input longint s,
                                                          input bit minus);
        longint sum;
        sum = minus ? a * c - b * s : a * c + b * s;
        sum = sum >>> 14;
        if (sum > 32767) return 16'sh7fff;
        if (sum < -32768) return 16'sh8000;
        return sum[15:0];
    endfunction

    function automatic logic signed [31:0] step_component(input longint p, input longint d,
                                                          input longint h);
        longint v;
        v = p + ((d * h) >>> 14);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input longint x,
                                          input longint y, input longint z,
                                          input logic [1:0] status);
        t_result r;
        r.kind = kind;
        r.x = x[31:0];
        r.y = y[31:0];
        r.z = z[31:0];
        r.status = status;
        r.last = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void restart_turtle();
        for (int i = 0; i < 3; i++) begin
            pos_hist[0][i] = start_pos[i];
            dir_hist[0][i] = start_dir[i];
        end
        pos_depth = 1;
        dir_depth = 1;
        mark_count = 0;
    endfunction

    function automatic void config_turtle(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_START_X:  start_pos[0] = data;
            REG_START_Y:  start_pos[1] = data;
            REG_START_Z:  start_pos[2] = data;
            REG_START_DX: start_dir[0] = data[15:0];
            REG_START_DY: start_dir[1] = data[15:0];
            REG_START_DZ: start_dir[2] = data[15:0];
            default: return;
        endcase
        restart_turtle();
    endfunction

    // expected results of one accepted item
    function automatic void turtle_predict(input logic [2:0] op, input longint c,
                                           input longint s, input longint d);
        int     queued_at_start;
        int     pos_to;
        int     dir_to;
        longint hx, hy, hz;
        queued_at_start = pending_results.size();
        if (op == OP_ROT_X || op == OP_ROT_Y || op == OP_ROT_Z) begin
            if (dir_depth >= Depth) begin
                expect_result(KIND_STATUS, 0, 0, 0, ST_OVERFLOW);
            end else begin
                hx = dir_hist[dir_depth-1][0];
                hy = dir_hist[dir_depth-1][1];
                hz = dir_hist[dir_depth-1][2];
                dir_hist[dir_depth][0] = hx;
                dir_hist[dir_depth][1] = hy;
                dir_hist[dir_depth][2] = hz;
                if (op == OP_ROT_X) begin
                    dir_hist[dir_depth][1] = turn_component(hy, c, hz, s, 1'b1);
                    dir_hist[dir_depth][2] = turn_component(hy, s, hz, c, 1'b0);
                end else if (op == OP_ROT_Y) begin
                    dir_hist[dir_depth][0] = turn_component(hx, c, hz, s, 1'b0);
                    dir_hist[dir_depth][2] = turn_component(hz, c, hx, s, 1'b1);
                end else begin
                    dir_hist[dir_depth][0] = turn_component(hx, c, hy, s, 1'b1);
                    dir_hist[dir_depth][1] = turn_component(hx, s, hy, c, 1'b0);
                end
                expect_result(KIND_HEADING, dir_hist[dir_depth][0], dir_hist[dir_depth][1],
                              dir_hist[dir_depth][2], ST_OK);
                dir_depth++;
            end
        end else if (op == OP_MOVE) begin
            if (pos_depth >= Depth) begin
                expect_result(KIND_STATUS, 0, 0, 0, ST_OVERFLOW);
            end else begin
                for (int i = 0; i < 3; i++)
                    pos_hist[pos_depth][i] = step_component(pos_hist[pos_depth-1][i], d,
                                                            dir_hist[dir_depth-1][i]);
                expect_result(KIND_VERTEX, pos_hist[pos_depth][0], pos_hist[pos_depth][1],
                              pos_hist[pos_depth][2], ST_OK);
                pos_depth++;
            end
        end else if (op == OP_SAVE) begin
            if (mark_count >= MarkSlots) begin
                expect_result(KIND_STATUS, 0, 0, 0, ST_OVERFLOW);
            end else begin
                mark_pos[mark_count] = pos_depth;
                mark_dir[mark_count] = dir_depth;
                mark_count++;
                expect_result(KIND_STATUS, 0, 0, 0, ST_OK);
            end
        end else if (op == OP_RESTORE) begin
            if (mark_count == 0) begin
                expect_result(KIND_STATUS, 0, 0, 0, ST_NO_SAVE);
            end else begin
                mark_count--;
                pos_to = mark_pos[mark_count];
                dir_to = mark_dir[mark_count];
                if (dir_to >= 1 && dir_to < dir_depth) dir_depth = dir_to;
                while (pos_to >= 1 && pos_depth > pos_to) begin
                    pos_depth--;
                    expect_result(KIND_VERTEX, pos_hist[pos_depth-1][0],
                                  pos_hist[pos_depth-1][1], pos_hist[pos_depth-1][2], ST_OK);
                end
                if (pending_results.size() == queued_at_start)
                    expect_result(KIND_STATUS, 0, 0, 0, ST_OK);
            end
        end else begin
            // unused codes are answered with a plain ok
            expect_result(KIND_STATUS, 0, 0, 0, ST_OK);
        end
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    // offer one item, predict on accept, then maybe pause
    task automatic send_item(input logic [2:0] op, input logic signed [15:0] c,
                             input logic signed [15:0] s, input logic signed [31:0] d);
        i_operation <= op;
        i_cos_value <= c;
        i_sin_value <= s;
        i_distance  <= d;
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        turtle_predict(op, c, s, d);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        config_turtle(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_start(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic signed [15:0] dx,
                              input logic signed [15:0] dy, input logic signed [15:0] dz);
        write_reg(REG_START_X, px);
        write_reg(REG_START_Y, py);
        write_reg(REG_START_Z, pz);
        write_reg(REG_START_DX, 32'(dx));
        write_reg(REG_START_DY, 32'(dy));
        write_reg(REG_START_DZ, 32'(dz));
    endtask

    // extremes of the distance field, every operation code and the named corner cases
    task automatic test_directed();
        send_item(OP_RESTORE, 0, 0, 0);
        send_item(OP_MOVE, 0, 0, 32'sh7fffffff);
        send_item(OP_MOVE, 0, 0, 32'sh80000000);
        send_item(OP_MOVE, 0, 0, 0);
        send_item(OP_SAVE, 0, 0, 0);
        send_item(OP_ROT_X, 16384, 0, 0);
        send_item(OP_ROT_Y, 0, 16384, 0);
        send_item(OP_ROT_Z, -16384, -16384, 0);
        send_item(OP_ROT_X, 11585, -11585, 0);
        send_item(OP_MOVE, 0, 0, 32'h0001_8000);
        send_item(OP_MOVE, 0, 0, -32'sd12345);
        send_item(OP_SAVE, 0, 0, 0);
        send_item(OP_RESTORE, 0, 0, 0);
        send_item(OP_RESTORE, 0, 0, 0);
        send_item(3'd6, -16384, 16384, 32'shffffffff);
        send_item(3'd7, 16383, -1, 32'sh55555555);
        send_item(OP_ROT_Y, 16384, 16384, 0);
        send_item(OP_ROT_Z, 16384, 16384, 0);
        send_item(OP_MOVE, 0, 0, 32'sh7fffffff);
        send_item(OP_RESTORE, 0, 0, 0);
        wait_idle();
    endtask

    // fill every stack, overflow each one, then walk the whole history back
    task automatic test_overflow();
        load_start(32'sh7fff0000, 32'sh80000000, 0, -32768, 32767, 16384);
        send_item(OP_SAVE, 0, 0, 0);
        repeat (Depth) send_item(OP_MOVE, 0, 0, $urandom_range(0, 32'h0003_ffff));
        repeat (Depth) send_item(OP_ROT_Z, $urandom_range(0, 16384),
                                 16'($urandom_range(0, 32768)) - 16'sd16384, 0);
        repeat (MarkSlots) send_item(OP_SAVE, 0, 0, 0);
        repeat (MarkSlots + 1) send_item(OP_RESTORE, 0, 0, 0);
        wait_idle();
    endtask

    function automatic logic signed [31:0] pick_distance();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    // mostly balanced save and restore groups with random content
    task automatic test_random(input int count);
        int                 pick;
        int                 open_marks;
        logic signed [15:0] c;
        logic signed [15:0] s;
        open_marks = 0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            c = 16'($urandom_range(0, 32768)) - 16'sd16384;
            s = 16'($urandom_range(0, 32768)) - 16'sd16384;
            if (n == count / 2) hold_request = 1'b1;
            if (pick < 25) begin
                send_item(3'($urandom_range(0, 2)), c, s, $urandom);
            end else if (pick < 55) begin
                send_item(OP_MOVE, c, s, pick_distance());
            end else if (pick < 70) begin
                send_item(OP_SAVE, c, s, $urandom);
                open_marks++;
            end else if (pick < 85 && open_marks > 0) begin
                send_item(OP_RESTORE, c, s, $urandom);
                open_marks--;
            end else if (pick < 96) begin
                send_item(OP_RESTORE, c, s, $urandom);
                if (open_marks > 0) open_marks--;
            end else begin
                send_item(3'($urandom_range(6, 7)), c, s, $urandom);
            end
        end
        wait_idle();
    endtask

    // receiver: check each result, stall on its own pattern
    always @(posedge i_clk) begin
        t_result r;
        if (o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                r = pending_results.pop_front();
                if (o_kind !== r.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", o_kind, r.kind));
                if (o_comp_x !== r.x)
                    report_mismatch($sformatf("comp_x %0d, expected %0d", o_comp_x, r.x));
                if (o_comp_y !== r.y)
                    report_mismatch($sformatf("comp_y %0d, expected %0d", o_comp_y, r.y));
                if (o_comp_z !== r.z)
                    report_mismatch($sformatf("comp_z %0d, expected %0d", o_comp_z, r.z));
                if (o_status !== r.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, r.status));
                if (o_last !== r.last)
                    report_mismatch($sformatf("last %0d, expected %0d", o_last, r.last));
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = 300;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                steady = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(8, 60);
            end else begin
                mode_left--;
            end
            i_ready <= steady || ($urandom_range(0, 2) != 0);
        end
    end

    // run limit
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        start_pos = '{0, 0, 0};
        start_dir = '{0, 16384, 0};
        restart_turtle();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        load_start(0, 0, 0, 0, 16384, 0);
        test_random(17);
        load_start($urandom, $urandom, $urandom, 11585, 0, -11585);
        test_random(17);
        load_start(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32767, 32767, 32767);
        test_random(17);
        load_start(32'sh80000000, 32'sh80000000, 32'sh80000000, -32768, -32768, -32768);
        test_random(17);
        $display("covered %0d items and %0d results over six register settings,",
                 items_sent, results_seen);
        $display("including full stacks, a full history walk and a long output stall");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
